// ===== hdl/bst_pkg.sv =====
// Package for the button sequence tester.
// Holds register addresses, reset values, phase and error code types,
// and the configuration struct shared by the register block and the top level.
package bst_pkg;

    localparam int MAX_BUTTONS_DEF = 16;

    localparam int CH_W    = 5;
    localparam int TIMER_W = 16;
    localparam int CODE_W  = 2;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [ADDR_W-1:0] ADDR_BUTTON_COUNT = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_HOLD_TICKS   = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_NOISE_TICKS  = 4'h8;

    localparam logic [CH_W-1:0]    BUTTON_COUNT_RST = 5'd16;
    localparam logic [TIMER_W-1:0] HOLD_TICKS_RST   = 16'd200;
    localparam logic [TIMER_W-1:0] NOISE_TICKS_RST  = 16'd100;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    typedef enum logic [1:0] {
        PH_WAIT_PRESS     = 2'd0,
        PH_STABLE_PRESS   = 2'd1,
        PH_WAIT_RELEASE   = 2'd2,
        PH_STABLE_RELEASE = 2'd3
    } phase_t;

    typedef enum logic [CODE_W-1:0] {
        ERR_NONE          = 2'd0,
        ERR_NOISY_PRESS   = 2'd1,
        ERR_NOISY_RELEASE = 2'd2
    } err_code_t;

    typedef enum logic {
        KIND_TICK    = 1'b0,
        KIND_RESTART = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic [CH_W-1:0]    button_count;
        logic [TIMER_W-1:0] hold_ticks;
        logic [TIMER_W-1:0] noise_ticks;
    } bst_cfg_t;

endpackage

// ===== hdl/bst_regs.sv =====
// Configuration registers of the button sequence tester behind an APB-style port.
// Depends on bst_pkg for addresses, reset values and the bst_cfg_t struct.
module bst_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bst_pkg::ADDR_W-1:0]    paddr,
    input  logic [bst_pkg::DATA_W-1:0]    pwdata,
    output logic [bst_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output bst_pkg::bst_cfg_t             cfg
);

    bst_pkg::bst_cfg_t cfg_reg;
    bst_pkg::bst_cfg_t cfg_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr)
                bst_pkg::ADDR_BUTTON_COUNT: cfg_next.button_count = pwdata[bst_pkg::CH_W-1:0];
                bst_pkg::ADDR_HOLD_TICKS:   cfg_next.hold_ticks   = pwdata[bst_pkg::TIMER_W-1:0];
                bst_pkg::ADDR_NOISE_TICKS:  cfg_next.noise_ticks  = pwdata[bst_pkg::TIMER_W-1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.button_count <= bst_pkg::BUTTON_COUNT_RST;
            cfg_reg.hold_ticks   <= bst_pkg::HOLD_TICKS_RST;
            cfg_reg.noise_ticks  <= bst_pkg::NOISE_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (paddr)
            bst_pkg::ADDR_BUTTON_COUNT:
                prdata = {{(bst_pkg::DATA_W-bst_pkg::CH_W){1'b0}}, cfg_reg.button_count};
            bst_pkg::ADDR_HOLD_TICKS:
                prdata = {{(bst_pkg::DATA_W-bst_pkg::TIMER_W){1'b0}}, cfg_reg.hold_ticks};
            bst_pkg::ADDR_NOISE_TICKS:
                prdata = {{(bst_pkg::DATA_W-bst_pkg::TIMER_W){1'b0}}, cfg_reg.noise_ticks};
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/button_sequence_tester.sv =====
// Top level of the button sequence tester: per-item test logic and result register.
// Depends on bst_pkg and instantiates bst_regs for the configuration port.
//
//   channel   handshake            payload
//   --------  -------------------  -----------------------------------------------
//   config    psel/penable/pready  pwrite, paddr, pwdata, prdata
//   input     in_valid/in_ready    kind, button_levels
//   output    out_valid/out_ready  channel_under_test, still_running, error_raised,
//                                  raised_code, error_map, test_phase
//
// One item per cycle while in_ready is high: test state and the result register update on the
// same edge the input transfer completes, so a result is valid from the cycle after its item.
// in_ready is low only while a result waits and out_ready is low.
// Reset clears the phase, timer, channel, all error codes and the result valid.
module button_sequence_tester
#(
    parameter int MAX_BUTTONS = bst_pkg::MAX_BUTTONS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bst_pkg::ADDR_W-1:0]         paddr,
    input  logic [bst_pkg::DATA_W-1:0]         pwdata,
    output logic [bst_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               kind,
    input  logic [MAX_BUTTONS-1:0]             button_levels,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bst_pkg::CH_W-1:0]           channel_under_test,
    output logic                               still_running,
    output logic                               error_raised,
    output logic [bst_pkg::CODE_W-1:0]         raised_code,
    output logic [2*MAX_BUTTONS-1:0]           error_map,
    output logic [1:0]                         test_phase
);

    localparam logic [bst_pkg::CH_W-1:0] MAX_CH = bst_pkg::CH_W'(MAX_BUTTONS);

    bst_pkg::bst_cfg_t cfg;

    bst_pkg::phase_t                phase_reg;
    bst_pkg::phase_t                phase_next;
    logic [bst_pkg::TIMER_W-1:0]    timer_reg;
    logic [bst_pkg::TIMER_W-1:0]    timer_next;
    logic [bst_pkg::CH_W-1:0]       channel_reg;
    logic [bst_pkg::CH_W-1:0]       channel_next;
    bst_pkg::err_code_t             err_reg  [MAX_BUTTONS];
    bst_pkg::err_code_t             err_next [MAX_BUTTONS];

    logic                           out_valid_reg;
    logic [bst_pkg::CH_W-1:0]       out_channel_reg;
    logic                           out_running_reg;
    logic                           out_raised_reg;
    logic [bst_pkg::CODE_W-1:0]     out_code_reg;
    logic [2*MAX_BUTTONS-1:0]       out_map_reg;
    logic [1:0]                     out_phase_reg;

    logic                           accept;
    logic [bst_pkg::CH_W-1:0]       eff_count;
    logic                           active;
    logic                           pressed;
    bst_pkg::err_code_t             cur_err;
    logic [bst_pkg::TIMER_W-1:0]    timer_inc;
    logic                           flag_en;
    bst_pkg::err_code_t             flag_code;
    logic                           raised;
    bst_pkg::err_code_t             res_code;
    logic [2*MAX_BUTTONS-1:0]       res_map;
    logic                           res_running;

    bst_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign eff_count = (cfg.button_count > MAX_CH) ? MAX_CH : cfg.button_count;
    assign active    = (channel_reg < eff_count);
    assign timer_inc = (timer_reg == bst_pkg::TIMER_MAX) ? timer_reg
                                                         : timer_reg + 1'b1;

    // select the level and stored code of the channel under test
    always_comb
    begin
        pressed = 1'b0;
        cur_err = bst_pkg::ERR_NONE;
        for (int i = 0; i < MAX_BUTTONS; i++)
        begin
            if (channel_reg == bst_pkg::CH_W'(i))
            begin
                pressed = button_levels[i];
                cur_err = err_reg[i];
            end
        end
    end

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        channel_next = channel_reg;
        flag_en      = 1'b0;
        flag_code    = bst_pkg::ERR_NONE;
        if (kind == bst_pkg::KIND_RESTART)
        begin
            phase_next   = bst_pkg::PH_WAIT_PRESS;
            timer_next   = '0;
            channel_next = '0;
        end
        else if (active)
        begin
            case (phase_reg)
                bst_pkg::PH_WAIT_PRESS:
                begin
                    if (pressed)
                    begin
                        phase_next = bst_pkg::PH_STABLE_PRESS;
                        timer_next = bst_pkg::TIMER_W'(1);
                    end
                end
                bst_pkg::PH_STABLE_PRESS:
                begin
                    timer_next = timer_inc;
                    if (timer_inc >= cfg.hold_ticks)
                    begin
                        phase_next = bst_pkg::PH_WAIT_RELEASE;
                    end
                    else if (!pressed && timer_inc > cfg.noise_ticks)
                    begin
                        flag_en   = 1'b1;
                        flag_code = bst_pkg::ERR_NOISY_PRESS;
                    end
                end
                bst_pkg::PH_WAIT_RELEASE:
                begin
                    if (!pressed)
                    begin
                        phase_next = bst_pkg::PH_STABLE_RELEASE;
                        timer_next = bst_pkg::TIMER_W'(1);
                    end
                end
                bst_pkg::PH_STABLE_RELEASE:
                begin
                    timer_next = timer_inc;
                    if (pressed)
                    begin
                        if (timer_inc > cfg.noise_ticks)
                        begin
                            flag_en   = 1'b1;
                            flag_code = bst_pkg::ERR_NOISY_RELEASE;
                        end
                    end
                    else if (timer_inc >= cfg.hold_ticks)
                    begin
                        channel_next = channel_reg + 1'b1;
                        phase_next   = bst_pkg::PH_WAIT_PRESS;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // raise only on a change of the channel's code
    assign raised = flag_en && (cur_err != flag_code);

    always_comb
    begin
        for (int i = 0; i < MAX_BUTTONS; i++)
        begin
            if (kind == bst_pkg::KIND_RESTART)
            begin
                err_next[i] = bst_pkg::ERR_NONE;
            end
            else if (raised && channel_reg == bst_pkg::CH_W'(i))
            begin
                err_next[i] = flag_code;
            end
            else
            begin
                err_next[i] = err_reg[i];
            end
        end
    end

    // result values
    always_comb
    begin
        res_code = bst_pkg::ERR_NONE;
        if (kind == bst_pkg::KIND_TICK && active)
        begin
            res_code = raised ? flag_code : cur_err;
        end
        for (int i = 0; i < MAX_BUTTONS; i++)
        begin
            res_map[2*i +: 2] = err_next[i];
        end
        res_running = (channel_next < eff_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= bst_pkg::PH_WAIT_PRESS;
            timer_reg   <= '0;
            channel_reg <= '0;
            for (int i = 0; i < MAX_BUTTONS; i++)
            begin
                err_reg[i] <= bst_pkg::ERR_NONE;
            end
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            channel_reg <= channel_next;
            for (int i = 0; i < MAX_BUTTONS; i++)
            begin
                err_reg[i] <= err_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the result until its transfer completes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_channel_reg <= channel_next;
            out_running_reg <= res_running;
            out_raised_reg  <= raised;
            out_code_reg    <= res_code;
            out_map_reg     <= res_map;
            out_phase_reg   <= phase_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign channel_under_test = out_channel_reg;
    assign still_running      = out_running_reg;
    assign error_raised       = out_raised_reg;
    assign raised_code        = out_code_reg;
    assign error_map          = out_map_reg;
    assign test_phase         = out_phase_reg;

endmodule
